// ===== design/rdb_pkg.sv =====
package rdb_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_REVERSE    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] popped_value;
        logic [4:0]         count;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } t_dp_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

    // slot reached by moving steps toward the back (toward the front when rev is flipped)
    function automatic logic [ADDR_W-1:0] slot_step(
        input logic [ADDR_W-1:0] base,
        input logic [CNT_W-1:0]  steps,
        input logic              rev
    );
        logic [CNT_W:0] d;
        logic [CNT_W:0] s;
        d = {1'b0, steps};
        if (d >= (CNT_W + 1)'(DEPTH)) begin
            d = d - (CNT_W + 1)'(DEPTH);
        end
        if (rev) begin
            s = (CNT_W + 1)'(base) + (CNT_W + 1)'(DEPTH) - d;
        end else begin
            s = (CNT_W + 1)'(base) + d;
        end
        if (s >= (CNT_W + 1)'(DEPTH)) begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

// ===== design/rdb_ctrl.sv =====
module rdb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  rdb_pkg::t_dp_stat i_stat,
    output rdb_pkg::t_dp_ctl  o_ctl
);
    import rdb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.load   = accept;
        o_ctl.exec   = (r_state == S_EXEC);
        o_ctl.finish = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted item did not start execution");

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_DONE))
        else $error("execute step not followed by done");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result shown without a finished item");

    a_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_stat.empty && i_stat.full))
        else $error("queue reported empty and full at once");
`endif

endmodule

// ===== design/rdb_datapath.sv =====
module rdb_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rdb_pkg::t_in_item  i_in,
    input  rdb_pkg::t_dp_ctl   i_ctl,
    output rdb_pkg::t_out_item o_out,
    output rdb_pkg::t_dp_stat  o_stat
);
    import rdb_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    t_cmd                  r_cmd;
    logic [DATA_WIDTH-1:0] r_value;
    logic [ADDR_W-1:0]     r_front, n_front;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_rev, n_rev;
    logic                  r_ok, n_ok;
    logic                  r_popped, n_popped;
    logic [DATA_WIDTH-1:0] r_rd_data;
    t_out_item             r_out;

    logic                  empty;
    logic                  full;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  rd_en;

    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = empty;
    assign o_stat.full  = full;
    assign o_out = r_out;

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_rev    = r_rev;
        n_ok     = 1'b0;
        n_popped = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_front;
        rd_en    = 1'b0;
        unique case (r_cmd)
            CMD_PUSH_FRONT: begin
                if (!full) begin
                    n_front = slot_step(r_front, CNT_W'(1), !r_rev);
                    wr_en   = 1'b1;
                    wr_addr = n_front;
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (!full) begin
                    wr_en   = 1'b1;
                    wr_addr = slot_step(r_front, r_count, r_rev);
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (!empty) begin
                    rd_en    = 1'b1;
                    n_front  = slot_step(r_front, CNT_W'(1), r_rev);
                    n_count  = r_count - 1'b1;
                    n_ok     = 1'b1;
                    n_popped = 1'b1;
                end
            end
            CMD_REVERSE: begin
                if (!empty) begin
                    n_front = slot_step(r_front, r_count - 1'b1, r_rev);
                end
                n_rev = !r_rev;
                n_ok  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && wr_en) begin
            mem[wr_addr] <= r_value;
        end
        if (i_ctl.exec && rd_en) begin
            r_rd_data <= mem[r_front];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_in.cmd;
            r_value <= DATA_WIDTH'(i_in.push_value);
        end
        if (i_ctl.exec) begin
            r_ok     <= n_ok;
            r_popped <= n_popped;
        end
        if (i_ctl.finish) begin
            r_out.ok           <= r_ok;
            r_out.popped_value <= r_popped ? 32'(r_rd_data) : 32'sd0;
            r_out.count        <= 5'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_ctl.exec) begin
            r_front <= n_front;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && r_cmd == CMD_POP_FRONT && !empty)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not lower occupancy");

    a_reverse_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && r_cmd == CMD_REVERSE) |=> (r_rev != $past(r_rev)))
        else $error("reverse did not flip direction");
`endif

endmodule

// ===== design/reversible_deque_buffer_core.sv =====
// Bounded double-ended queue of signed 32-bit values in a 16-entry ring store.
// Input channel: i_in_valid / o_in_stall carry one item (cmd, push_value).
// Commands: push front, push back, pop front, reverse order.
// Output channel: o_out_valid / i_out_stall carry one result item per input
// item (ok, popped_value, count), in order.
// A push when full or a pop when empty returns ok = 0 and changes nothing.
// Reverse is constant time: the front index jumps to the old back slot and
// a direction bit flips.
// Timing: each item passes through accept, execute and result load in turn, set by the
// control sequencer and the registered read of the ring store. The next item is
// accepted only after the result load. o_out_valid is registered with the result.
// The result register frees the input side: a new item is accepted while a
// result still waits. If the receiver stalls, the result holds, and the next
// item waits in its done step until the result register frees.
// Reset (synchronous, active low) empties the queue, sets forward direction
// and drops o_out_valid. Store contents are not cleared.
module reversible_deque_buffer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  rdb_pkg::t_in_item  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output rdb_pkg::t_out_item o_out,
    input  logic               i_out_stall
);
    import rdb_pkg::*;

    t_dp_ctl  ctl;
    t_dp_stat stat;

    rdb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    rdb_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctl   (ctl),
        .o_out   (o_out),
        .o_stat  (stat)
    );

endmodule
